@@ hdl/gpe_pkg.sv @@
package gpe_pkg;

    localparam int MAX_SIZE = 64;
    localparam int SUBSTEPS = 100;

    localparam int SZW = 7;
    localparam int SGW = 16;
    localparam int RCW = 6;
    localparam int GRW = 8;
    localparam int CIW = 1;

    localparam int KW  = $clog2(SUBSTEPS + 1);
    localparam int AW  = $clog2(MAX_SIZE / 2 * SUBSTEPS + 1);
    localparam int XW  = AW + 1;
    localparam int DXW = SZW + 1;
    localparam int SW  = 2 * AW + 1;
    localparam int SQW = 2 * SGW;
    localparam int DW  = SQW + $clog2(SUBSTEPS * SUBSTEPS + 1);

    localparam int FB     = 24;
    localparam int IB     = 5;
    localparam int QW     = IB + FB;
    localparam int PRE_SH = 23 - IB;
    localparam int CMPW   = (SW + PRE_SH > DW) ? SW + PRE_SH : DW;

    localparam int LGW = 25;
    localparam int LNW = 30;
    localparam int GNW = 28;
    localparam logic [LGW-1:0] LOG2E_Q24 = 25'd24204406;
    localparam logic [LNW-1:0] LN2_Q30   = 30'd744261118;
    localparam logic [GNW-1:0] GAIN_Q24  = 28'd170884644;

    localparam int UW  = QW + 1;
    localparam int NW  = UW - FB;
    localparam int YW  = 30;
    localparam int TQ  = 30;
    localparam int TW  = 31;
    localparam int SMW = TW + 2;
    localparam int NT  = 12;
    localparam int KBW = $clog2(NT + 1);
    localparam int RCPW = 33;
    localparam int RSH  = 32;

    localparam logic [RCPW-1:0] RECIP [1:NT] = '{
        33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
        33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
        33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941
    };

    localparam int GW      = 26;
    localparam int ACW     = 42;
    localparam int SAT_INT = 26;
    localparam int SATW    = DW + 5;
    localparam int PW      = QW + GNW;
    localparam int GSH     = 48;
    localparam int CNW     = $clog2(QW);

    localparam logic [CIW-1:0] CFG_SIZE  = 1'b0;
    localparam logic [CIW-1:0] CFG_SIGMA = 1'b1;

    typedef struct packed {
        logic       vld;
        logic       lst;
        logic       skp;
        logic [1:0] wsh;
    } t_side;

    typedef struct packed {
        logic go;
        logic zero;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_DEN, S_RUN, S_WAIT
    } t_seq_st;

    typedef enum logic [2:0] {
        F_IDLE, F_ACC, F_CHK, F_DIV, F_MUL, F_SAT, F_OUT
    } t_fin_st;

endpackage

@@ hdl/gpe_seq.sv @@
module gpe_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_acc,
    input  logic [gpe_pkg::RCW-1:0]    i_row,
    input  logic [gpe_pkg::RCW-1:0]    i_col,
    input  logic [gpe_pkg::SZW-1:0]    i_size,
    input  logic [gpe_pkg::SGW-1:0]    i_sigma,
    input  logic                       i_done,
    output logic                       o_busy,
    output gpe_pkg::t_job              o_job,
    output logic [gpe_pkg::DW-1:0]     o_den,
    output logic [gpe_pkg::DW-1:0]     o_p0,
    output gpe_pkg::t_side             o_side
);
    import gpe_pkg::*;

    t_seq_st r_st, n_st;
    logic [SZW-1:0] w_size, w_half;
    logic           w_out;
    logic signed [DXW-1:0] w_dx, w_dy;
    logic signed [XW-1:0]  r_x0, r_y0, w_cx, w_cy;
    logic [SGW-1:0] r_sg;
    logic [SQW-1:0] r_sq;
    logic [DW-1:0]  r_den;
    logic [KW-1:0]  r_kx, r_ky;
    logic           w_last, w_ex, w_ey;
    logic           r_go, r_zero;

    logic [AW-1:0]   r_ax, r_ay;
    logic [2*AW-1:0] r_sqx, r_sqy;
    logic [SW-1:0]   w_s;
    logic [SW+PRE_SH-1:0] w_num;
    logic [DW-1:0]   r_p0;
    t_side r_s1, r_s2, r_s3, w_s1, w_s3;

    always_comb begin
        w_size = (i_size > SZW'(MAX_SIZE)) ? SZW'(MAX_SIZE) : i_size;
        w_half = w_size >> 1;
        w_out  = (SZW'(i_row) >= w_size) || (SZW'(i_col) >= w_size);
        w_dx   = $signed(DXW'(i_row)) - $signed(DXW'(w_half));
        w_dy   = $signed(DXW'(i_col)) - $signed(DXW'(w_half));
        w_ex   = (r_kx == '0) || (r_kx == KW'(SUBSTEPS));
        w_ey   = (r_ky == '0) || (r_ky == KW'(SUBSTEPS));
        w_last = (r_kx == KW'(SUBSTEPS)) && (r_ky == KW'(SUBSTEPS));
        w_cx   = r_x0 + $signed(XW'(r_kx));
        w_cy   = r_y0 + $signed(XW'(r_ky));
        w_s1.vld = (r_st == S_RUN);
        w_s1.lst = w_last;
        w_s1.skp = 1'b0;
        w_s1.wsh = {1'b0, !w_ex} + {1'b0, !w_ey};
        w_s    = SW'(r_sqx) + SW'(r_sqy);
        w_num  = {w_s, PRE_SH'(0)};
        w_s3     = r_s2;
        w_s3.skp = CMPW'(w_num) >= CMPW'(r_den);
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: begin
                if (i_acc) begin
                    n_st = w_out ? S_WAIT : S_SQ;
                end
            end
            S_SQ:  n_st = S_DEN;
            S_DEN: n_st = S_RUN;
            S_RUN: begin
                if (w_last) begin
                    n_st = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_done) begin
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_go <= 1'b0;
            r_kx <= '0;
            r_ky <= '0;
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_st <= n_st;
            r_go <= i_acc;
            r_s1 <= w_s1;
            r_s2 <= r_s1;
            r_s3 <= w_s3;
            if (i_acc) begin
                r_kx <= '0;
                r_ky <= '0;
            end else if (r_st == S_RUN) begin
                if (r_ky == KW'(SUBSTEPS)) begin
                    r_ky <= '0;
                    r_kx <= r_kx + 1'b1;
                end else begin
                    r_ky <= r_ky + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_x0   <= XW'(w_dx * SUBSTEPS);
            r_y0   <= XW'(w_dy * SUBSTEPS);
            r_sg   <= (i_sigma == '0) ? SGW'(1) : i_sigma;
            r_zero <= w_out;
        end
        r_sq  <= r_sg * r_sg;
        r_den <= DW'(r_sq * DW'(SUBSTEPS * SUBSTEPS));
        r_ax  <= AW'(w_cx[XW-1] ? -w_cx : w_cx);
        r_ay  <= AW'(w_cy[XW-1] ? -w_cy : w_cy);
        r_sqx <= r_ax * r_ax;
        r_sqy <= r_ay * r_ay;
        r_p0  <= DW'(w_num);
    end

    assign o_busy   = (r_st != S_IDLE);
    assign o_job.go   = r_go;
    assign o_job.zero = r_zero;
    assign o_den  = r_den;
    assign o_p0   = r_p0;
    assign o_side = r_s3;

endmodule

@@ hdl/gpe_tdiv.sv @@
module gpe_tdiv (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [gpe_pkg::DW-1:0]  i_den,
    input  logic [gpe_pkg::DW-1:0]  i_p0,
    input  gpe_pkg::t_side          i_side,
    output logic [gpe_pkg::QW-1:0]  o_t,
    output gpe_pkg::t_side          o_side
);
    import gpe_pkg::*;

    logic [DW-1:0] r_p  [0:QW-1];
    logic [QW-1:0] r_q  [0:QW-1];
    t_side         r_sd [0:QW-1];

    // one quotient bit per stage, remainder doubles in
    for (genvar i = 0; i < QW; i++) begin : g_stg
        logic [DW-1:0] w_pin;
        logic [QW-1:0] w_qin;
        t_side         w_sin;
        logic [DW:0]   w_two;
        logic          w_ge;

        if (i == 0) begin : g_first
            assign w_pin = i_p0;
            assign w_qin = '0;
            assign w_sin = i_side;
        end else begin : g_rest
            assign w_pin = r_p[i-1];
            assign w_qin = r_q[i-1];
            assign w_sin = r_sd[i-1];
        end

        assign w_two = {w_pin, 1'b0};
        assign w_ge  = w_two >= {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            r_p[i] <= w_ge ? DW'(w_two - {1'b0, i_den}) : DW'(w_two);
            r_q[i] <= {w_qin[QW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd[i] <= '0;
            end else begin
                r_sd[i] <= w_sin;
            end
        end
    end

    assign o_t    = r_q[QW-1];
    assign o_side = r_sd[QW-1];

endmodule

@@ hdl/gpe_nexp.sv @@
module gpe_nexp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [gpe_pkg::QW-1:0]  i_t,
    input  gpe_pkg::t_side          i_side,
    output logic [gpe_pkg::GW-1:0]  o_g,
    output gpe_pkg::t_side          o_side
);
    import gpe_pkg::*;

    typedef struct packed {
        logic [YW-1:0]         y;
        logic [NW-1:0]         n;
        logic signed [SMW-1:0] sum;
        logic [TW-1:0]         p;
        logic [TW-1:0]         q;
    } t_ex;

    logic [QW+LGW-1:0] w_mu;
    logic [FB+LNW-1:0] w_my;
    logic [UW-1:0]     r_u;
    logic [YW-1:0]     r_y;
    logic [NW-1:0]     r_n;
    t_side             r_sd0, r_sd1, r_sdo;
    t_ex               w_c0;

    t_ex   r_a  [1:NT];
    t_ex   r_b  [1:NT];
    t_ex   r_c  [1:NT];
    t_side r_sa [1:NT];
    t_side r_sb [1:NT];
    t_side r_sc [1:NT];

    logic [SMW-2:0] w_pos;
    logic [NW:0]    w_sh;
    logic [GW-1:0]  r_g;

    assign w_mu = i_t * LOG2E_Q24;
    assign w_my = r_u[FB-1:0] * LN2_Q30;

    always_comb begin
        w_c0.y   = r_y;
        w_c0.n   = r_n;
        w_c0.sum = SMW'(1) <<< TQ;
        w_c0.p   = TW'(1) << TQ;
        w_c0.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        r_u <= w_mu[FB+UW-1:FB];
        r_y <= w_my[FB+YW-1:FB];
        r_n <= r_u[UW-1:FB];
    end

    // Taylor terms: multiply, reciprocal, correct and fold into the sum
    for (genvar k = 1; k <= NT; k++) begin : g_term
        t_ex   w_cin;
        t_side w_sin;
        logic [TW+YW-1:0]   w_pa;
        logic [TW+RCPW-1:0] w_pb;
        logic [TW+KBW-1:0]  w_qk, w_rem;
        logic               w_up;
        logic [TW-1:0]      w_term;
        t_ex                w_na, w_nb, w_nc;

        if (k == 1) begin : g_first
            assign w_cin = w_c0;
            assign w_sin = r_sd1;
        end else begin : g_rest
            assign w_cin = r_c[k-1];
            assign w_sin = r_sc[k-1];
        end

        assign w_pa   = w_cin.p * w_cin.y;
        assign w_pb   = r_a[k].p * RECIP[k];
        assign w_qk   = (TW+KBW)'(r_b[k].q) * (TW+KBW)'(k);
        assign w_rem  = (TW+KBW)'(r_b[k].p) - w_qk;
        assign w_up   = w_rem >= (TW+KBW)'(k);
        assign w_term = w_up ? r_b[k].q + 1'b1 : r_b[k].q;

        always_comb begin
            w_na     = w_cin;
            w_na.p   = w_pa[TQ+TW-1:TQ];
            w_nb     = r_a[k];
            w_nb.q   = w_pb[RSH+TW-1:RSH];
            w_nc     = r_b[k];
            w_nc.p   = w_term;
            w_nc.sum = (k % 2 == 1) ? r_b[k].sum - $signed(SMW'(w_term))
                                    : r_b[k].sum + $signed(SMW'(w_term));
        end

        always_ff @(posedge i_clk) begin
            r_a[k] <= w_na;
            r_b[k] <= w_nb;
            r_c[k] <= w_nc;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sa[k] <= '0;
                r_sb[k] <= '0;
                r_sc[k] <= '0;
            end else begin
                r_sa[k] <= w_sin;
                r_sb[k] <= r_sa[k];
                r_sc[k] <= r_sb[k];
            end
        end
    end

    always_comb begin
        w_pos = r_c[NT].sum[SMW-1] ? '0 : r_c[NT].sum[SMW-2:0];
        w_sh  = {1'b0, r_c[NT].n} + (NW+1)'(6);
    end

    always_ff @(posedge i_clk) begin
        r_g <= GW'(w_pos >> w_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd0 <= '0;
            r_sd1 <= '0;
            r_sdo <= '0;
        end else begin
            r_sd0 <= i_side;
            r_sd1 <= r_sd0;
            r_sdo <= r_sc[NT];
        end
    end

    assign o_g    = r_g;
    assign o_side = r_sdo;

endmodule

@@ hdl/gpe_fin.sv @@
module gpe_fin (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  gpe_pkg::t_job           i_job,
    input  logic [gpe_pkg::DW-1:0]  i_den,
    input  logic [gpe_pkg::GW-1:0]  i_g,
    input  gpe_pkg::t_side          i_side,
    output logic                    o_strobe,
    output logic [gpe_pkg::GRW-1:0] o_gray
);
    import gpe_pkg::*;

    t_fin_st r_st, n_st;
    logic [ACW-1:0] r_acc, n_acc;
    logic [DW-1:0]  r_p, n_p;
    logic [QW-1:0]  r_q, n_q;
    logic [IB-1:0]  r_lo, n_lo;
    logic [CNW-1:0] r_cnt, n_cnt;
    logic [PW-1:0]  r_prod, n_prod;
    logic [GRW-1:0] r_gray, n_gray;
    logic [DW:0]    w_two;
    logic           w_ge, w_sat;
    logic [PW-GSH-1:0] w_hi;

    always_comb begin
        w_two = {r_p, r_lo[IB-1]};
        w_ge  = w_two >= {1'b0, i_den};
        w_sat = SATW'(r_acc) >= SATW'(i_den) * SATW'(SAT_INT);
        w_hi  = r_prod[PW-1:GSH];
    end

    always_comb begin
        n_st   = r_st;
        n_acc  = r_acc;
        n_p    = r_p;
        n_q    = r_q;
        n_lo   = r_lo;
        n_cnt  = r_cnt;
        n_prod = r_prod;
        n_gray = r_gray;
        unique case (r_st)
            F_IDLE: begin
                if (i_job.go) begin
                    n_acc  = '0;
                    n_gray = '0;
                    n_st   = i_job.zero ? F_OUT : F_ACC;
                end
            end
            F_ACC: begin
                if (i_side.vld) begin
                    if (!i_side.skp) begin
                        n_acc = r_acc + (ACW'(i_g) << i_side.wsh);
                    end
                    if (i_side.lst) begin
                        n_st = F_CHK;
                    end
                end
            end
            F_CHK: begin
                n_p   = DW'(r_acc >> IB);
                n_lo  = r_acc[IB-1:0];
                n_q   = '0;
                n_cnt = '0;
                if (w_sat) begin
                    n_gray = '1;
                    n_st   = F_OUT;
                end else begin
                    n_st = F_DIV;
                end
            end
            F_DIV: begin
                n_p   = w_ge ? DW'(w_two - {1'b0, i_den}) : DW'(w_two);
                n_q   = {r_q[QW-2:0], w_ge};
                n_lo  = r_lo << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNW'(QW - 1)) begin
                    n_st = F_MUL;
                end
            end
            F_MUL: begin
                n_prod = r_q * GAIN_Q24;
                n_st   = F_SAT;
            end
            F_SAT: begin
                n_gray = (w_hi > (PW-GSH)'(255)) ? '1 : GRW'(w_hi);
                n_st   = F_OUT;
            end
            F_OUT:   n_st = F_IDLE;
            default: n_st = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= F_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_p    <= n_p;
        r_q    <= n_q;
        r_lo   <= n_lo;
        r_cnt  <= n_cnt;
        r_prod <= n_prod;
        r_gray <= n_gray;
    end

    assign o_strobe = (r_st == F_OUT);
    assign o_gray   = r_gray;

endmodule

@@ hdl/gaussian_psf_pixel_energy.sv @@
// Sequence: for a pixel inside the image, o_strobe rises after the set-up states (SQ, DEN),
// the 101 x 101 corner sweep at one Gaussian sample per cycle, the 71-stage sample
// pipeline and a tail (saturation check, 29-step serial normalising divide, gain multiply,
// clamp). A pixel outside the image strobes 0 without a sweep.
// Throughput: one pixel at a time; busy falls at the edge that ends the strobe, so the
// next start is taken only after the strobe of the previous one.
// Reset: synchronous active low; image_size returns to 12 and sigma to 1.0.
module gaussian_psf_pixel_energy (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [gpe_pkg::RCW-1:0]  i_row,
    input  logic [gpe_pkg::RCW-1:0]  i_col,
    output logic                     o_strobe,
    output logic [gpe_pkg::GRW-1:0]  o_gray,
    input  logic                     i_cfg_we,
    input  logic [gpe_pkg::CIW-1:0]  i_cfg_idx,
    input  logic [gpe_pkg::SGW-1:0]  i_cfg_data
);
    import gpe_pkg::*;

    logic [SZW-1:0] r_size;
    logic [SGW-1:0] r_sigma;
    logic           w_acc;
    t_job           w_job;
    logic [DW-1:0]  w_den, w_p0;
    logic [QW-1:0]  w_t;
    logic [GW-1:0]  w_g;
    t_side          w_sd_seq, w_sd_div, w_sd_exp;

    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SZW'(12);
            r_sigma <= SGW'(4096);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIZE:  r_size  <= i_cfg_data[SZW-1:0];
                CFG_SIGMA: r_sigma <= i_cfg_data;
                default:   r_size  <= r_size;
            endcase
        end
    end

    gpe_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_row   (i_row),
        .i_col   (i_col),
        .i_size  (r_size),
        .i_sigma (r_sigma),
        .i_done  (o_strobe),
        .o_busy  (busy),
        .o_job   (w_job),
        .o_den   (w_den),
        .o_p0    (w_p0),
        .o_side  (w_sd_seq)
    );

    gpe_tdiv u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_den   (w_den),
        .i_p0    (w_p0),
        .i_side  (w_sd_seq),
        .o_t     (w_t),
        .o_side  (w_sd_div)
    );

    gpe_nexp u_nexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_t     (w_t),
        .i_side  (w_sd_div),
        .o_g     (w_g),
        .o_side  (w_sd_exp)
    );

    gpe_fin u_fin (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_job),
        .i_den    (w_den),
        .i_g      (w_g),
        .i_side   (w_sd_exp),
        .o_strobe (o_strobe),
        .o_gray   (o_gray)
    );

endmodule

@@ hdl/gpe_chk.sv @@
module gpe_chk (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_strobe
);

    // a result only ever ends a transaction in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("more than one result for a transaction");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_strobe))
        else $error("busy dropped without a result");

endmodule

bind gaussian_psf_pixel_energy gpe_chk u_gpe_chk (.*);

@@ tb/tb_gaussian_psf_pixel_energy.sv @@
module tb_gaussian_psf_pixel_energy;
    import gpe_pkg::*;

    typedef struct packed {
        logic [RCW-1:0] row;
        logic [RCW-1:0] col;
    } t_pixel;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    logic [RCW-1:0]  i_row = '0;
    logic [RCW-1:0]  i_col = '0;
    logic            o_strobe;
    logic [GRW-1:0]  o_gray;
    logic            i_cfg_we = 1'b0;
    logic [CIW-1:0]  i_cfg_idx = CFG_SIZE;
    logic [SGW-1:0]  i_cfg_data = '0;

    t_pixel          pixel_q[$];
    logic [GRW-1:0]  gray_q[$];
    int              n_errors = 0;
    int              burst_left = 0;
    int              gap_left = 0;
    logic [SZW-1:0]  cur_size = 7'd12;
    logic [SGW-1:0]  cur_sigma = 16'd4096;

    gaussian_psf_pixel_energy u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_row      (i_row),
        .i_col      (i_col),
        .o_strobe   (o_strobe),
        .o_gray     (o_gray),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // floor(num * 2^24 / den)
    function automatic longint unsigned div_frac24(longint unsigned num,
                                                   longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = num / den;
        r = num % den;
        for (int b = 0; b < 24; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned decay_q24(longint unsigned t);
        longint unsigned u;
        longint unsigned n;
        longint unsigned y;
        longint unsigned term;
        longint          sum;
        u = (t * 64'd24204406) >> 24;
        n = u >> 24;
        y = ((u & 64'hFFFFFF) * 64'd744261118) >> 24;
        sum = 64'sd1 <<< 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * y) >> 30) / k;
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (n + 6 > 63)
            return 0;
        return longint'(unsigned'(sum)) >> (n + 6);
    endfunction

    function automatic logic [GRW-1:0] pixel_gray(t_pixel px);
        longint unsigned size;
        longint unsigned sg;
        longint unsigned den;
        longint unsigned acc;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned wx;
        longint unsigned wy;
        longint unsigned num;
        longint unsigned g;
        longint unsigned r;
        longint unsigned gray;
        longint          c;
        longint          x0;
        longint          y0;
        longint          v;
        size = (cur_size > MAX_SIZE) ? MAX_SIZE : cur_size;
        sg = (cur_sigma == 0) ? 1 : cur_sigma;
        den = 64'd10000 * sg * sg;
        acc = 0;
        if (px.row >= size || px.col >= size)
            return '0;
        c = longint'(size >> 1);
        x0 = (longint'(px.row) - c) * SUBSTEPS;
        y0 = (longint'(px.col) - c) * SUBSTEPS;
        for (int kx = 0; kx <= SUBSTEPS; kx++) begin
            v = x0 + kx;
            ax = (v < 0) ? -v : v;
            wx = (kx == 0 || kx == SUBSTEPS) ? 1 : 2;
            for (int ky = 0; ky <= SUBSTEPS; ky++) begin
                v = y0 + ky;
                ay = (v < 0) ? -v : v;
                wy = (ky == 0 || ky == SUBSTEPS) ? 1 : 2;
                num = (ax * ax + ay * ay) << 23;
                if (num >= (den << 5))
                    g = 0;
                else
                    g = decay_q24(div_frac24(num, den));
                acc = acc + wx * wy * g;
            end
        end
        if (acc / den >= 26) begin
            gray = 255;
        end else begin
            r = div_frac24(acc, den);
            gray = (r * 64'd170884644) >> 48;
            if (gray > 255)
                gray = 255;
        end
        return gray[GRW-1:0];
    endfunction

    task automatic report(string what);
        $display("mismatch: %s", what);
        n_errors++;
    endtask

    // driver: bursts of transactions with random gaps
    always @(posedge i_clk) begin
        t_pixel px;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                gray_q = {gray_q, pixel_gray(t_pixel'{row: i_row, col: i_col})};
            if (start && busy) begin
                // hold until accepted
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                px = pixel_q.pop_front();
                start <= 1'b1;
                i_row <= px.row;
                i_col <= px.col;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 6);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [GRW-1:0] want;
        if (i_rst_n && o_strobe) begin
            if (gray_q.size() == 0) begin
                report($sformatf("unexpected gray %0d", o_gray));
            end else begin
                want = gray_q.pop_front();
                if (o_gray !== want)
                    report($sformatf("gray %0d, expected %0d (size %0d sigma %0d)",
                                     o_gray, want, cur_size, cur_sigma));
            end
        end
    end

    task automatic write_reg(logic [CIW-1:0] idx, logic [SGW-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SIZE)
            cur_size = data[SZW-1:0];
        else
            cur_sigma = data;
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0 || gray_q.size() != 0 || start || busy)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic add_pixel(int r, int c);
        t_pixel px;
        px.row = RCW'(r);
        px.col = RCW'(c);
        pixel_q = {pixel_q, px};
    endtask

    task automatic add_random(int count, int span);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) == 0)
                add_pixel($urandom_range(0, 63), $urandom_range(0, 63));
            else
                add_pixel($urandom_range(0, span), $urandom_range(0, span));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: corners, centre, edges and outside
        add_pixel(0, 0);
        add_pixel(11, 11);
        add_pixel(6, 6);
        add_pixel(5, 6);
        add_pixel(0, 11);
        add_pixel(12, 0);
        add_pixel(0, 12);
        add_pixel(63, 63);
        add_pixel(63, 0);
        add_pixel(42, 21);
        wait_idle();

        write_reg(CFG_SIZE, 16'd64);
        write_reg(CFG_SIGMA, 16'd0);
        add_pixel(32, 32);
        add_pixel(0, 0);
        add_pixel(63, 63);
        add_pixel(31, 32);
        wait_idle();

        write_reg(CFG_SIZE, 16'd127);
        write_reg(CFG_SIGMA, 16'd65535);
        add_pixel(32, 32);
        add_pixel(0, 63);
        add_pixel(63, 0);
        wait_idle();

        write_reg(CFG_SIZE, 16'd0);
        add_pixel(0, 0);
        add_pixel(21, 42);
        wait_idle();

        write_reg(CFG_SIZE, 16'd1);
        write_reg(CFG_SIGMA, 16'd1);
        add_pixel(0, 0);
        add_pixel(1, 0);
        wait_idle();

        // upper data bits beyond the size field are dropped
        write_reg(CFG_SIZE, 16'hFF83);
        write_reg(CFG_SIGMA, 16'd2048);
        add_random(8, 3);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_SIZE, 16'($urandom_range(1, 70)));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_SIGMA, 16'($urandom_range(1, 1024)));
                1: write_reg(CFG_SIGMA, 16'($urandom_range(1024, 16384)));
                2: write_reg(CFG_SIGMA, 16'($urandom_range(16384, 65535)));
                default: write_reg(CFG_SIGMA, 16'($urandom));
            endcase
            add_random(11, (cur_size == 0) ? 0 : ((cur_size > 64) ? 63 : cur_size - 1));
            wait_idle();
        end

        repeat (50) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
